// File: rtl/core/rtotw_pkg.sv
// package: types, constants and codes for the 2-opt route block
package rtotw_pkg;

   localparam int TOWNS = 64;
   localparam int TOWN_W = 6;
   localparam int TIME_W = 40;
   localparam int SUM_W = 42;
   localparam int DEF_MAX_STOPS = 64;
   localparam int LEN_W = 7;
   localparam int ADDR_W = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_TRAVEL = 2'd0;
   localparam logic [1:0] OP_STOP = 2'd1;
   localparam logic [1:0] OP_RUN = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [ADDR_W-1:0] REG_LENGTH = 5'h00;
   localparam logic [ADDR_W-1:0] REG_START = 5'h08;
   localparam logic [ADDR_W-1:0] REG_END = 5'h10;

   typedef struct packed {
      logic [1:0] operation;
      logic [TOWN_W-1:0] town_a;
      logic [TOWN_W-1:0] town_b;
      logic [TIME_W-1:0] travel_time;
      logic [TOWN_W-1:0] position;
      logic [TOWN_W-1:0] stop_town;
      logic [TIME_W-1:0] window_start;
      logic [TIME_W-1:0] window_end;
      logic [TIME_W-1:0] service_time;
   } req_type;

   typedef struct packed {
      logic [TOWN_W-1:0] position_res;
      logic [TOWN_W-1:0] stop_town_res;
      logic [TIME_W-1:0] best_time;
      logic feasible;
      logic [TIME_W-1:0] updated_start_time;
      logic last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EV_FIRST,
      ST_EV_LEG,
      ST_EV_LEG2,
      ST_EV_RET,
      ST_EV_RET2,
      ST_DECIDE,
      ST_BUILD,
      ST_COPY,
      ST_EMIT
   } back_state_type;

endpackage

// File: rtl/core/rtotw_front.sv
// front part: takes items, drops unused codes and queues the rest
module rtotw_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  rtotw_pkg::req_type req_data,
   output logic q_valid,
   input  logic q_ready,
   output rtotw_pkg::req_type q_data
);
   import rtotw_pkg::*;

   req_type q_mem [QUEUE_DEPTH];
   logic q_wp_ff, q_wp_in, q_rp_ff, q_rp_in;
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic push, pop, keep;

   assign req_ready = (q_cnt_ff != 2'(QUEUE_DEPTH));
   assign keep = (req_data.operation == OP_TRAVEL) || (req_data.operation == OP_STOP)
      || (req_data.operation == OP_RUN);
   assign push = req_valid && req_ready && keep;
   assign q_valid = (q_cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_data = q_mem[q_rp_ff];
   assign q_wp_in = push ? ~q_wp_ff : q_wp_ff;
   assign q_rp_in = pop ? ~q_rp_ff : q_rp_ff;
   assign q_cnt_in = q_cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff <= 1'b0;
         q_rp_ff <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         q_wp_ff <= q_wp_in;
         q_rp_ff <= q_rp_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[q_wp_ff] <= req_data;
      end
   end
endmodule

// File: rtl/core/rtotw_back.sv
// back part: tables, route evaluation, 2-opt sweep and result output
module rtotw_back #(
   parameter int MAX_STOPS = rtotw_pkg::DEF_MAX_STOPS
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  rtotw_pkg::req_type q_data,
   input  logic [rtotw_pkg::LEN_W-1:0] route_length,
   input  logic [rtotw_pkg::TIME_W-1:0] start_time,
   input  logic [rtotw_pkg::TIME_W-1:0] end_time,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rtotw_pkg::rsp_type rsp_data
);
   import rtotw_pkg::*;

   localparam int PW = $clog2(MAX_STOPS);
   localparam int CW = $clog2(MAX_STOPS + 1);
   localparam int LIM = (MAX_STOPS < TOWNS) ? MAX_STOPS : TOWNS;

   logic [TIME_W-1:0] travel_mem [TOWNS*TOWNS];
   logic [TIME_W-1:0] open_mem [TOWNS];
   logic [TIME_W-1:0] close_mem [TOWNS];
   logic [TIME_W-1:0] serv_mem [TOWNS];
   logic [TOWN_W-1:0] best_mem [MAX_STOPS];
   logic [TOWN_W-1:0] trial_mem [MAX_STOPS];

   back_state_type state_ff, state_in;
   logic [1:0] sub_ff, sub_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] a_ff, a_in, b_ff, b_in;
   logic searching_ff, searching_in;
   logic bvalid_ff, bvalid_in;
   logic [TIME_W-1:0] btime_ff, btime_in;
   logic [SUM_W-1:0] t_ff, t_in;
   logic ok_ff, ok_in;
   logic [TOWN_W-1:0] prev_ff, prev_in, first_ff, first_in;
   logic [TOWN_W-1:0] rd_town_ff;
   logic [TIME_W-1:0] rd_trav_ff, rd_open_ff, rd_close_ff, rd_serv_ff;
   rsp_type out_ff, out_in;
   logic out_v_ff, out_v_in;

   logic [CW-1:0] n_sel;
   logic [CW-1:0] rd_idx;
   logic rd_trial;
   logic [TOWN_W-1:0] tr_p, tr_q;
   logic [CW-1:0] src_idx;
   logic [SUM_W-1:0] leg_sum, leg_max;
   logic [SUM_W-1:0] cand;

   assign n_sel = (route_length > LEN_W'(LIM)) ? CW'(LIM) : CW'(route_length);
   // a travel item stays at the queue head until its mirrored entry is written
   assign q_ready = (state_ff == ST_IDLE && q_data.operation != OP_TRAVEL)
      || (state_ff == ST_EXEC);
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   // index of the trial entry built at position i: reversed inside a..b
   assign src_idx = (i_ff >= a_ff && i_ff <= b_ff) ? CW'(a_ff + b_ff - i_ff) : i_ff;

   // route reads: one order entry per cycle, then the towns' data
   always_ff @(posedge clock) begin
      if (rd_trial) begin
         rd_town_ff <= trial_mem[rd_idx[PW-1:0]];
      end else begin
         rd_town_ff <= best_mem[rd_idx[PW-1:0]];
      end
      rd_trav_ff <= travel_mem[{tr_p, tr_q}];
      rd_open_ff <= open_mem[rd_town_ff];
      rd_close_ff <= close_mem[rd_town_ff];
      rd_serv_ff <= serv_mem[rd_town_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_data.operation == OP_TRAVEL) begin
         travel_mem[{q_data.town_a, q_data.town_b}] <= q_data.travel_time;
      end else if (state_ff == ST_EXEC) begin
         travel_mem[{q_data.town_b, q_data.town_a}] <= q_data.travel_time;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_data.operation == OP_STOP) begin
         open_mem[q_data.stop_town] <= q_data.window_start;
         close_mem[q_data.stop_town] <= q_data.window_end;
         serv_mem[q_data.stop_town] <= q_data.service_time;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_data.operation == OP_STOP
         && 32'(q_data.position) < 32'(MAX_STOPS)) begin
         best_mem[PW'(q_data.position)] <= q_data.stop_town;
      end else if (state_ff == ST_COPY && sub_ff == 2'd1) begin
         best_mem[i_ff[PW-1:0]] <= rd_town_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_BUILD && sub_ff == 2'd1) begin
         trial_mem[i_ff[PW-1:0]] <= rd_town_ff;
      end
   end

   assign leg_sum = t_ff + SUM_W'(rd_trav_ff) + SUM_W'(rd_serv_ff);
   assign leg_max = (leg_sum < SUM_W'(rd_open_ff)) ? SUM_W'(rd_open_ff) : leg_sum;
   assign cand = t_ff - SUM_W'(start_time);

   always_comb begin
      rd_trial = searching_ff;
      rd_idx = i_ff;
      tr_p = prev_ff;
      tr_q = rd_town_ff;
      case (state_ff)
         ST_BUILD: begin
            rd_trial = 1'b0;
            rd_idx = src_idx;
         end
         ST_COPY: begin
            rd_trial = 1'b1;
         end
         ST_EMIT: begin
            rd_trial = 1'b0;
         end
         ST_EV_RET: begin
            tr_p = first_ff;
            tr_q = prev_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_data.operation)
                  OP_TRAVEL: state_in = ST_EXEC;
                  OP_RUN: state_in = (n_sel == '0) ? ST_EMIT : ST_EV_FIRST;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         ST_EV_FIRST: if (sub_ff == 2'd1) state_in = (n_ff == CW'(1)) ? ST_EV_RET : ST_EV_LEG;
         ST_EV_LEG: if (sub_ff == 2'd2) state_in = ST_EV_LEG2;
         ST_EV_LEG2: begin
            if (leg_max > SUM_W'(rd_close_ff) || leg_max > SUM_W'(end_time)) begin
               state_in = ST_DECIDE;
            end else if (i_ff + CW'(1) == n_ff) begin
               state_in = ST_EV_RET;
            end else begin
               state_in = ST_EV_LEG;
            end
         end
         ST_EV_RET: if (sub_ff == 2'd1) state_in = ST_EV_RET2;
         ST_EV_RET2: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!searching_ff) begin
               if (ok_ff && cand == '0) state_in = ST_EMIT;
               else if (n_ff == CW'(1)) state_in = ST_EMIT;
               else state_in = ST_BUILD;
            end else if (ok_ff && (!bvalid_ff || cand < SUM_W'(btime_ff))) begin
               state_in = ST_COPY;
            end else if (b_ff + CW'(1) < n_ff) begin
               state_in = ST_BUILD;
            end else if (a_ff + CW'(2) < n_ff) begin
               state_in = ST_BUILD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_BUILD: if (sub_ff == 2'd1 && i_ff + CW'(1) == n_ff) state_in = ST_EV_FIRST;
         ST_COPY: begin
            if (sub_ff == 2'd1 && i_ff + CW'(1) == n_ff) begin
               if (b_ff + CW'(1) < n_ff || a_ff + CW'(2) < n_ff) state_in = ST_BUILD;
               else state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sub_ff == 2'd1 && (!out_v_ff || rsp_ready)
               && (n_ff == '0 || i_ff + CW'(1) == n_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sub_in = sub_ff;
      n_in = n_ff;
      i_in = i_ff;
      a_in = a_ff;
      b_in = b_ff;
      searching_in = searching_ff;
      bvalid_in = bvalid_ff;
      btime_in = btime_ff;
      t_in = t_ff;
      ok_in = ok_ff;
      prev_in = prev_ff;
      first_in = first_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            sub_in = 2'd0;
            i_in = '0;
            n_in = n_sel;
            searching_in = 1'b0;
            a_in = '0;
            b_in = '0;
            bvalid_in = 1'b0;
            btime_in = '0;
         end
         ST_EV_FIRST: begin
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else begin
               first_in = rd_town_ff;
               prev_in = rd_town_ff;
               t_in = SUM_W'(start_time);
               ok_in = 1'b1;
               sub_in = 2'd0;
               i_in = (n_ff == CW'(1)) ? '0 : CW'(1);
            end
         end
         ST_EV_LEG: begin
            sub_in = sub_ff + 2'd1;
         end
         ST_EV_LEG2: begin
            sub_in = 2'd0;
            t_in = leg_max;
            prev_in = rd_town_ff;
            i_in = i_ff + CW'(1);
            if (leg_max > SUM_W'(rd_close_ff) || leg_max > SUM_W'(end_time)) begin
               ok_in = 1'b0;
            end
         end
         ST_EV_RET: begin
            sub_in = sub_ff + 2'd1;
         end
         ST_EV_RET2: begin
            sub_in = 2'd0;
            t_in = t_ff + SUM_W'(rd_trav_ff);
            if (t_ff + SUM_W'(rd_trav_ff) > SUM_W'(end_time)) ok_in = 1'b0;
         end
         ST_DECIDE: begin
            i_in = '0;
            sub_in = 2'd0;
            if (!searching_ff) begin
               searching_in = 1'b1;
               bvalid_in = ok_ff && cand != '0;
               btime_in = (ok_ff && cand != '0) ? TIME_W'(cand) : '0;
               a_in = '0;
               b_in = CW'(1);
               if (ok_ff && cand == '0) begin
                  searching_in = 1'b0;
               end
            end else if (ok_ff && (!bvalid_ff || cand < SUM_W'(btime_ff))) begin
               bvalid_in = 1'b1;
               btime_in = TIME_W'(cand);
            end else if (b_ff + CW'(1) < n_ff) begin
               b_in = b_ff + CW'(1);
            end else begin
               a_in = a_ff + CW'(1);
               b_in = a_ff + CW'(2);
            end
         end
         ST_BUILD: begin
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else begin
               sub_in = 2'd0;
               i_in = (i_ff + CW'(1) == n_ff) ? '0 : i_ff + CW'(1);
            end
         end
         ST_COPY: begin
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else begin
               sub_in = 2'd0;
               i_in = (i_ff + CW'(1) == n_ff) ? '0 : i_ff + CW'(1);
               if (i_ff + CW'(1) == n_ff) begin
                  if (b_ff + CW'(1) < n_ff) begin
                     b_in = b_ff + CW'(1);
                  end else begin
                     a_in = a_ff + CW'(1);
                     b_in = a_ff + CW'(2);
                  end
               end
            end
         end
         ST_EMIT: begin
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else if (!out_v_ff || rsp_ready) begin
               sub_in = 2'd0;
               out_v_in = 1'b1;
               out_in.position_res = TOWN_W'(i_ff);
               out_in.stop_town_res = (n_ff == '0) ? '0 : rd_town_ff;
               out_in.best_time = bvalid_ff ? btime_ff : '0;
               out_in.feasible = bvalid_ff;
               out_in.updated_start_time = bvalid_ff ? TIME_W'(start_time + btime_ff)
                  : start_time;
               out_in.last = (n_ff == '0) || (i_ff + CW'(1) == n_ff);
               i_in = i_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sub_ff <= 2'd0;
         out_v_ff <= 1'b0;
         searching_ff <= 1'b0;
         bvalid_ff <= 1'b0;
         btime_ff <= '0;
      end else begin
         state_ff <= state_in;
         sub_ff <= sub_in;
         out_v_ff <= out_v_in;
         searching_ff <= searching_in;
         bvalid_ff <= bvalid_in;
         btime_ff <= btime_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      i_ff <= i_in;
      a_ff <= a_in;
      b_ff <= b_in;
      t_ff <= t_in;
      ok_ff <= ok_in;
      prev_ff <= prev_in;
      first_ff <= first_in;
      out_ff <= out_in;
   end
endmodule

// File: rtl/core/route_two_opt_time_windows.sv
// top level: configuration registers, front queue and 2-opt back end
//  channel | ports  | direction | moves
//  request | req_*  | in        | load or run item
//  result  | rsp_*  | out       | one stop of the best route per item
//  config  | p*     | in/out    | route_length, start_time, end_time (64-bit apb)
// stop loads are written while the back end idles; travel loads also pass ST_EXEC for the
// mirrored entry. A run evaluates each candidate leg by leg through the single travel-table
// port, copies a candidate into the best order when it becomes the best, sweeps up to
// N*(N-1)/2 candidates, then emits the stops one by one, held while rsp stalls.
// reset is synchronous and clears control state only; stores are undefined until
// written. rsp stalls hold the back end; the front queue keeps taking two items.
module route_two_opt_time_windows #(
   parameter int MAX_STOPS = rtotw_pkg::DEF_MAX_STOPS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  rtotw_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rtotw_pkg::rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [rtotw_pkg::ADDR_W-1:0] paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic pready
);
   import rtotw_pkg::*;

   logic [LEN_W-1:0] len_ff;
   logic [TIME_W-1:0] start_ff, end_ff;
   logic wr;
   logic q_valid, q_ready;
   req_type q_data;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_comb begin
      case (paddr)
         REG_LENGTH: prdata = 64'(len_ff);
         REG_START: prdata = 64'(start_ff);
         REG_END: prdata = 64'(end_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         start_ff <= '0;
         end_ff <= '0;
      end else if (wr) begin
         case (paddr)
            REG_LENGTH: len_ff <= pwdata[LEN_W-1:0];
            REG_START: start_ff <= pwdata[TIME_W-1:0];
            REG_END: end_ff <= pwdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rtotw_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   rtotw_back #(.MAX_STOPS(MAX_STOPS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .route_length(len_ff), .start_time(start_ff), .end_time(end_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
